// ===== src/aoi_pkg.sv =====
// Shared constants, types and helper functions for the linear octree index block.
`timescale 1ns / 1ps
`default_nettype none

package aoi_pkg;

    // Deepest tree the datapath is built for
    localparam int MAX_LEVELS = 8;

    // Fixed field widths
    localparam int COORD_W = 32;
    localparam int LVL_W   = 4;
    localparam int IDX_W   = 25;

    // Corner coordinates: lo x/y/z at 0..2, hi x/y/z at 3..5
    localparam int NAXIS  = 3;
    localparam int NCOORD = 2 * NAXIS;

    // Morton code width and the width of the index sum before masking
    localparam int CODE_W = 3 * MAX_LEVELS;
    localparam int SUM_W  = (CODE_W + 1 > IDX_W) ? CODE_W + 1 : IDX_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_ORIGIN_Z    = 3'd2,
        REG_INV_CELL_X  = 3'd3,
        REG_INV_CELL_Y  = 3'd4,
        REG_INV_CELL_Z  = 3'd5,
        REG_TREE_LEVELS = 3'd6
    } cfg_reg_t;

    typedef logic [NCOORD-1:0][COORD_W-1:0] coords_t;

    // Volume setup as seen by the datapath
    typedef struct packed {
        logic [NAXIS-1:0][COORD_W-1:0] origin;
        logic [NAXIS-1:0][COORD_W-1:0] inv_cell;
        logic [LVL_W-1:0]              levels;   // already limited to 1..MAX_LEVELS
    } cfg_t;

    // Offsets from the origin, with a below-origin mark per coordinate
    typedef struct packed {
        logic [NCOORD-1:0]              neg;
        logic [NCOORD-1:0][COORD_W-1:0] off;
    } offset_t;

    // Upper half of each scaled offset, i.e. the unclamped cell
    typedef struct packed {
        logic [NCOORD-1:0]              neg;
        logic [NCOORD-1:0][COORD_W-1:0] cell_raw;
    } scaled_t;

    // Interleaved corner code and the enclosing level
    typedef struct packed {
        logic [CODE_W-1:0] m_lo;
        logic [LVL_W-1:0]  up;
        logic [LVL_W-1:0]  levels;
        logic              outside;
    } coded_t;

    // Number of nodes above depth d: (8^d - 1) / 7
    function automatic logic [SUM_W-1:0] tree_base(input logic [LVL_W-1:0] depth);
        logic [SUM_W-1:0] acc;
        logic [SUM_W-1:0] one;
        acc = '0;
        one = SUM_W'(1);
        for (int k = 0; k < MAX_LEVELS; k++)
        begin
            if (LVL_W'(k) < depth)
            begin
                acc = acc + (one << (3 * k));
            end
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ===== src/aoi_if.sv =====
// Stream interfaces for box words in and node words out.
`timescale 1ns / 1ps
`default_nettype none

interface aoi_box_if;
    logic                              valid;
    logic                              ready;
    logic signed [aoi_pkg::COORD_W-1:0] lo_x;
    logic signed [aoi_pkg::COORD_W-1:0] lo_y;
    logic signed [aoi_pkg::COORD_W-1:0] lo_z;
    logic signed [aoi_pkg::COORD_W-1:0] hi_x;
    logic signed [aoi_pkg::COORD_W-1:0] hi_y;
    logic signed [aoi_pkg::COORD_W-1:0] hi_z;

    modport source (output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, input ready);
    modport sink   (input valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, output ready);
endinterface

interface aoi_node_if;
    logic                        valid;
    logic                        ready;
    logic [aoi_pkg::IDX_W-1:0]   node_index;
    logic [aoi_pkg::LVL_W-1:0]   node_depth;
    logic                        outside;

    modport source (output valid, node_index, node_depth, outside, input ready);
    modport sink   (input valid, node_index, node_depth, outside, output ready);
endinterface

`default_nettype wire

// ===== src/aabb_to_linear_octree_index.sv =====
// Top level: configuration registers and the four-stage index pipeline.
//
// Maps an axis-aligned box (Q16.16 corners) to the linear octree index and depth of
// the smallest node enclosing it, and flags boxes that reach outside the volume.
// One box word is taken per clock through four register stages: origin subtract,
// 32x32 reciprocal multiply, clamp and Morton interleave, then index add into the
// output register, from which each result goes out on the node port. Back-pressure on the
// node side stalls the pipeline stage by stage; bubbles are squeezed out. Write the
// configuration registers only while no box is in flight; tree_levels of 0 acts as 1
// and values above 8 act as 8.
`timescale 1ns / 1ps
`default_nettype none

module aabb_to_linear_octree_index (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [aoi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [aoi_pkg::COORD_W-1:0]     cfg_data,
    aoi_box_if.sink                              box,
    aoi_node_if.source                           node
);

    logic [aoi_pkg::NAXIS-1:0][aoi_pkg::COORD_W-1:0] origin_reg;
    logic [aoi_pkg::NAXIS-1:0][aoi_pkg::COORD_W-1:0] inv_cell_reg;
    logic [aoi_pkg::LVL_W-1:0]                       tree_levels_reg;
    logic [aoi_pkg::LVL_W-1:0]                       levels_eff;
    aoi_pkg::cfg_t                                   cfg;
    aoi_pkg::coords_t                                coords;
    logic                                            scl_valid;
    logic                                            scl_ready;
    aoi_pkg::scaled_t                                scl_data;
    logic                                            cod_valid;
    logic                                            cod_ready;
    aoi_pkg::coded_t                                 cod_data;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg      <= '0;
            inv_cell_reg    <= {aoi_pkg::NAXIS{aoi_pkg::COORD_W'(65536)}};
            tree_levels_reg <= aoi_pkg::LVL_W'(1);
        end
        else if (cfg_we)
        begin
            case (aoi_pkg::cfg_reg_t'(cfg_index))
                aoi_pkg::REG_ORIGIN_X:    origin_reg[0]   <= cfg_data;
                aoi_pkg::REG_ORIGIN_Y:    origin_reg[1]   <= cfg_data;
                aoi_pkg::REG_ORIGIN_Z:    origin_reg[2]   <= cfg_data;
                aoi_pkg::REG_INV_CELL_X:  inv_cell_reg[0] <= cfg_data;
                aoi_pkg::REG_INV_CELL_Y:  inv_cell_reg[1] <= cfg_data;
                aoi_pkg::REG_INV_CELL_Z:  inv_cell_reg[2] <= cfg_data;
                aoi_pkg::REG_TREE_LEVELS: tree_levels_reg <= cfg_data[aoi_pkg::LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // Limit the level count to 1..MAX_LEVELS
    always_comb
    begin
        if (tree_levels_reg == '0)
        begin
            levels_eff = aoi_pkg::LVL_W'(1);
        end
        else if (tree_levels_reg > aoi_pkg::LVL_W'(aoi_pkg::MAX_LEVELS))
        begin
            levels_eff = aoi_pkg::LVL_W'(aoi_pkg::MAX_LEVELS);
        end
        else
        begin
            levels_eff = tree_levels_reg;
        end
    end

    assign cfg.origin   = origin_reg;
    assign cfg.inv_cell = inv_cell_reg;
    assign cfg.levels   = levels_eff;

    // Gather corners, lo first
    assign coords = {box.hi_z, box.hi_y, box.hi_x, box.lo_z, box.lo_y, box.lo_x};

    aoi_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (box.valid),
        .in_ready  (box.ready),
        .in_coord  (coords),
        .out_valid (scl_valid),
        .out_ready (scl_ready),
        .out_data  (scl_data)
    );

    aoi_encode u_encode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (scl_valid),
        .in_ready  (scl_ready),
        .in_data   (scl_data),
        .out_valid (cod_valid),
        .out_ready (cod_ready),
        .out_data  (cod_data)
    );

    aoi_index u_index (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cod_valid),
        .in_ready (cod_ready),
        .in_data  (cod_data),
        .node     (node)
    );

endmodule

`default_nettype wire

// ===== src/aoi_scale.sv =====
// Offset and scale stages: corner minus origin, then times the reciprocal cell size.
`timescale 1ns / 1ps
`default_nettype none

module aoi_scale (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire aoi_pkg::cfg_t    cfg,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire aoi_pkg::coords_t in_coord,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output aoi_pkg::scaled_t      out_data
);

    logic             off_valid_reg;
    aoi_pkg::offset_t off_reg;
    aoi_pkg::offset_t off_next;
    logic             scl_valid_reg;
    aoi_pkg::scaled_t scl_reg;
    aoi_pkg::scaled_t scl_next;
    logic             off_ready;
    logic             scl_ready;

    // Advance a stage when it is empty or its word moves on
    assign scl_ready = !scl_valid_reg || out_ready;
    assign off_ready = !off_valid_reg || scl_ready;
    assign in_ready  = off_ready;

    for (genvar c = 0; c < aoi_pkg::NCOORD; c++)
    begin : g_coord
        localparam int AX = c % aoi_pkg::NAXIS;
        logic [aoi_pkg::COORD_W:0]     diff;
        logic [2*aoi_pkg::COORD_W-1:0] prod;

        // Subtract the origin at one extra bit; the top bit marks below the origin
        assign diff = {in_coord[c][aoi_pkg::COORD_W-1], in_coord[c]}
                    - {cfg.origin[AX][aoi_pkg::COORD_W-1], cfg.origin[AX]};
        assign off_next.neg[c] = diff[aoi_pkg::COORD_W];
        assign off_next.off[c] = diff[aoi_pkg::COORD_W-1:0];

        // Scale by the Q16.16 reciprocal; the cell is the part above bit 31
        assign prod = {{aoi_pkg::COORD_W{1'b0}}, off_reg.off[c]}
                    * {{aoi_pkg::COORD_W{1'b0}}, cfg.inv_cell[AX]};
        assign scl_next.cell_raw[c] = prod[2*aoi_pkg::COORD_W-1:aoi_pkg::COORD_W];
    end

    assign scl_next.neg = off_reg.neg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_valid_reg <= 1'b0;
            scl_valid_reg <= 1'b0;
        end
        else
        begin
            if (off_ready)
            begin
                off_valid_reg <= in_valid;
            end
            if (scl_ready)
            begin
                scl_valid_reg <= off_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (off_ready && in_valid)
        begin
            off_reg <= off_next;
        end
        if (scl_ready && off_valid_reg)
        begin
            scl_reg <= scl_next;
        end
    end

    assign out_valid = scl_valid_reg;
    assign out_data  = scl_reg;

endmodule

`default_nettype wire

// ===== src/aoi_encode.sv =====
// Clamp stage: limit cells to the grid, interleave into Morton codes, find the enclosing level.
`timescale 1ns / 1ps
`default_nettype none

module aoi_encode (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire aoi_pkg::cfg_t    cfg,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire aoi_pkg::scaled_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output aoi_pkg::coded_t       out_data
);

    logic                                             cod_valid_reg;
    aoi_pkg::coded_t                                  cod_reg;
    aoi_pkg::coded_t                                  cod_next;
    logic [aoi_pkg::COORD_W-1:0]                      max_cell;
    logic [aoi_pkg::NCOORD-1:0][aoi_pkg::MAX_LEVELS-1:0] cell_pos;
    logic [aoi_pkg::NCOORD-1:0]                       clamped;
    logic [aoi_pkg::CODE_W-1:0]                       m_lo;
    logic [aoi_pkg::CODE_W-1:0]                       m_hi;
    logic [aoi_pkg::CODE_W-1:0]                       m_diff;
    logic [aoi_pkg::LVL_W-1:0]                        up;

    assign in_ready = !cod_valid_reg || out_ready;

    // Largest cell on each axis
    assign max_cell = (aoi_pkg::COORD_W'(1) << cfg.levels) - aoi_pkg::COORD_W'(1);

    // Clamp each coordinate into 0..max_cell
    always_comb
    begin
        for (int c = 0; c < aoi_pkg::NCOORD; c++)
        begin
            if (in_data.neg[c])
            begin
                cell_pos[c] = '0;
                clamped[c]  = 1'b1;
            end
            else if (in_data.cell_raw[c] > max_cell)
            begin
                cell_pos[c] = max_cell[aoi_pkg::MAX_LEVELS-1:0];
                clamped[c]  = 1'b1;
            end
            else
            begin
                cell_pos[c] = in_data.cell_raw[c][aoi_pkg::MAX_LEVELS-1:0];
                clamped[c]  = 1'b0;
            end
        end
    end

    // Interleave: x in bit 0, y in bit 1, z in bit 2 of each group
    always_comb
    begin
        for (int i = 0; i < aoi_pkg::MAX_LEVELS; i++)
        begin
            for (int a = 0; a < aoi_pkg::NAXIS; a++)
            begin
                m_lo[3*i+a] = cell_pos[a][i];
                m_hi[3*i+a] = cell_pos[aoi_pkg::NAXIS+a][i];
            end
        end
    end

    // Highest differing group sets how many levels to climb
    assign m_diff = m_lo ^ m_hi;
    always_comb
    begin
        up = '0;
        for (int i = 0; i < aoi_pkg::MAX_LEVELS; i++)
        begin
            if (|m_diff[3*i +: 3])
            begin
                up = aoi_pkg::LVL_W'(i + 1);
            end
        end
    end

    assign cod_next.m_lo    = m_lo;
    assign cod_next.up      = up;
    assign cod_next.levels  = cfg.levels;
    assign cod_next.outside = |clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cod_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            cod_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cod_reg <= cod_next;
        end
    end

    assign out_valid = cod_valid_reg;
    assign out_data  = cod_reg;

endmodule

`default_nettype wire

// ===== src/aoi_index.sv =====
// Index stage: node depth and linear index, held in the output register.
`timescale 1ns / 1ps
`default_nettype none

module aoi_index (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire aoi_pkg::coded_t in_data,
    aoi_node_if.source           node
);

    logic                        res_valid_reg;
    logic [aoi_pkg::IDX_W-1:0]   index_reg;
    logic [aoi_pkg::IDX_W-1:0]   index_next;
    logic [aoi_pkg::LVL_W-1:0]   depth_reg;
    logic [aoi_pkg::LVL_W-1:0]   depth_next;
    logic                        outside_reg;
    logic [aoi_pkg::LVL_W+1:0]   shift;
    logic [aoi_pkg::CODE_W-1:0]  node_code;
    logic [aoi_pkg::SUM_W-1:0]   sum;

    assign in_ready = !res_valid_reg || node.ready;

    // Depth of the enclosing node and its code at that depth
    assign depth_next = in_data.levels - in_data.up;
    assign shift      = {2'b00, in_data.up} + {1'b0, in_data.up, 1'b0};
    assign node_code  = in_data.m_lo >> shift;

    // Add the count of all nodes above this depth
    assign sum = aoi_pkg::tree_base(depth_next)
               + {{(aoi_pkg::SUM_W - aoi_pkg::CODE_W){1'b0}}, node_code};
    assign index_next = sum[aoi_pkg::IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            res_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            index_reg   <= index_next;
            depth_reg   <= depth_next;
            outside_reg <= in_data.outside;
        end
    end

    assign node.valid      = res_valid_reg;
    assign node.node_index = index_reg;
    assign node.node_depth = depth_reg;
    assign node.outside    = outside_reg;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the box to linear octree index block.
`timescale 1ns / 1ps

module tb;
    import aoi_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] node_index;
        logic [LVL_W-1:0] node_depth;
        logic             outside;
    } node_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;

    aoi_box_if  box_bus ();
    aoi_node_if node_bus ();

    aabb_to_linear_octree_index u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .box       (box_bus),
        .node      (node_bus)
    );

    // Volume setup as last written
    logic [COORD_W-1:0] vol_origin [3];
    logic [COORD_W-1:0] vol_inv_cell [3];
    logic [LVL_W-1:0]   vol_levels;

    coords_t    box_pending [$];
    node_word_t expected_nodes [$];
    coords_t    box_offered;
    int         mismatches;
    int         burst_left;
    int         gap_left;
    int         results_seen;
    int         hold_left;
    int         cycle_count;

    // Levels in use: zero acts as one, anything above the maximum acts as the maximum
    function automatic int eff_levels();
        if (vol_levels == 0)
        begin
            return 1;
        end
        if (vol_levels > MAX_LEVELS)
        begin
            return MAX_LEVELS;
        end
        return vol_levels;
    endfunction

    // Grid cell of one coordinate; bit 32 marks a clamp
    function automatic logic [32:0] grid_cell(input logic [COORD_W-1:0] pos, input int axis,
                                              input int lv);
        logic [33:0] offset;
        logic [63:0] scaled;
        logic [31:0] top;
        offset = {{2{pos[31]}}, pos} - {{2{vol_origin[axis][31]}}, vol_origin[axis]};
        top = (32'd1 << lv) - 32'd1;
        if (offset[33])
        begin
            return {1'b1, 32'd0};
        end
        scaled = {32'd0, offset[31:0]} * {32'd0, vol_inv_cell[axis]};
        if (scaled[63:32] > top)
        begin
            return {1'b1, top};
        end
        return {1'b0, scaled[63:32]};
    endfunction

    // Smallest enclosing node of a box under the current volume setup
    function automatic node_word_t enclose_box(input coords_t c);
        int                lv;
        int                up;
        int                depth;
        int                a;
        int                b;
        logic [32:0]       gc;
        logic [CODE_W-1:0] code_lo;
        logic [CODE_W-1:0] code_hi;
        logic [31:0]       base;
        logic              clamped;
        node_word_t        r;
        lv = eff_levels();
        clamped = 1'b0;
        code_lo = '0;
        code_hi = '0;
        for (a = 0; a < NAXIS; a++)
        begin
            gc = grid_cell(c[a], a, lv);
            clamped = clamped | gc[32];
            for (b = 0; b < lv; b++)
            begin
                code_lo[3 * b + a] = gc[b];
            end
            gc = grid_cell(c[a + NAXIS], a, lv);
            clamped = clamped | gc[32];
            for (b = 0; b < lv; b++)
            begin
                code_hi[3 * b + a] = gc[b];
            end
        end
        // highest differing group sets how far up the node sits
        up = 0;
        for (b = 0; b < lv; b++)
        begin
            if (code_lo[3 * b +: 3] != code_hi[3 * b +: 3])
            begin
                up = b + 1;
            end
        end
        depth = lv - up;
        base = 32'd0;
        for (b = 0; b < depth; b++)
        begin
            base = base + (32'd1 << (3 * b));
        end
        r.node_index = IDX_W'(base + 32'(code_lo >> (3 * up)));
        r.node_depth = LVL_W'(depth);
        r.outside    = clamped;
        return r;
    endfunction

    // Position along one axis that lands in (or near) the given cell
    function automatic logic [COORD_W-1:0] place_in_cell(input int axis,
                                                         input logic [31:0] cell_num);
        logic [63:0] d;
        if (vol_inv_cell[axis] == 0)
        begin
            d = 64'($urandom_range(0, 1000));
        end
        else
        begin
            d = {cell_num, 32'($urandom)} / {32'd0, vol_inv_cell[axis]};
        end
        return vol_origin[axis] + d[31:0];
    endfunction

    task automatic queue_box(input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] lz,
                             input logic [31:0] hx, input logic [31:0] hy, input logic [31:0] hz);
        coords_t c;
        c[0] = lx;
        c[1] = ly;
        c[2] = lz;
        c[3] = hx;
        c[4] = hy;
        c[5] = hz;
        box_pending = {box_pending, c};
    endtask

    // Mostly boxes nested in some node with random content, the rest noise
    task automatic queue_random_box();
        coords_t     c;
        int          lv;
        int          keep;
        int          kind;
        int          a;
        logic [31:0] top;
        logic [31:0] low_mask;
        logic [31:0] cell_lo;
        logic [31:0] cell_hi;
        logic [31:0] t;
        lv = eff_levels();
        top = (32'd1 << lv) - 32'd1;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            for (a = 0; a < NCOORD; a++)
            begin
                c[a] = $urandom;
            end
        end
        else
        begin
            keep = $urandom_range(0, lv);
            low_mask = (32'd1 << (lv - keep)) - 32'd1;
            for (a = 0; a < NAXIS; a++)
            begin
                cell_lo = $urandom & top;
                cell_hi = (kind == 1) ? cell_lo : ((cell_lo & ~low_mask) | ($urandom & low_mask));
                if (kind == 2 && $urandom_range(0, 1) == 1)
                begin
                    cell_hi = top + $urandom_range(1, 3);
                end
                c[a] = place_in_cell(a, cell_lo);
                c[a + NAXIS] = place_in_cell(a, cell_hi);
                if (kind == 3 && $urandom_range(0, 1) == 1)
                begin
                    c[a] = vol_origin[a] - $urandom_range(1, 1 << 20);
                end
            end
            if (kind == 4)
            begin
                for (a = 0; a < NAXIS; a++)
                begin
                    t = c[a];
                    c[a] = c[a + NAXIS];
                    c[a + NAXIS] = t;
                end
            end
        end
        box_pending = {box_pending, c};
    endtask

    // Write one register and track it in the volume setup
    task automatic write_reg(input cfg_reg_t idx, input logic [COORD_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z:
                vol_origin[idx - REG_ORIGIN_X] = data;
            REG_INV_CELL_X, REG_INV_CELL_Y, REG_INV_CELL_Z:
                vol_inv_cell[idx - REG_INV_CELL_X] = data;
            REG_TREE_LEVELS:
                vol_levels = data[LVL_W-1:0];
            default:
                ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every box is sent and every node word is back
    task automatic wait_idle();
        while (box_pending.size() != 0 || expected_nodes.size() != 0 || box_bus.valid)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Send box words in bursts with random gaps; log each accepted word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_bus.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (box_bus.valid && box_bus.ready)
            begin
                expected_nodes = {expected_nodes, enclose_box(box_offered)};
            end
            if (!box_bus.valid || box_bus.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    box_bus.valid <= 1'b0;
                end
                else if (box_pending.size() > 0)
                begin
                    box_offered = box_pending.pop_front();
                    box_bus.lo_x  <= box_offered[0];
                    box_bus.lo_y  <= box_offered[1];
                    box_bus.lo_z  <= box_offered[2];
                    box_bus.hi_x  <= box_offered[3];
                    box_bus.hi_y  <= box_offered[4];
                    box_bus.hi_z  <= box_offered[5];
                    box_bus.valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    box_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Check node words and stall the output on a pattern of its own
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_bus.ready <= 1'b0;
            results_seen = 0;
            hold_left = 0;
            cycle_count = 0;
        end
        else
        begin
            if (node_bus.valid && node_bus.ready)
            begin
                if (expected_nodes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: node word with none expected: index %0d depth %0d outside %0d",
                             $time, node_bus.node_index, node_bus.node_depth, node_bus.outside);
                end
                else
                begin
                    node_word_t want;
                    want = expected_nodes.pop_front();
                    if (node_bus.node_index !== want.node_index)
                    begin
                        mismatches++;
                        $display("%0t: node_index expected %0d actual %0d",
                                 $time, want.node_index, node_bus.node_index);
                    end
                    if (node_bus.node_depth !== want.node_depth)
                    begin
                        mismatches++;
                        $display("%0t: node_depth expected %0d actual %0d",
                                 $time, want.node_depth, node_bus.node_depth);
                    end
                    if (node_bus.outside !== want.outside)
                    begin
                        mismatches++;
                        $display("%0t: outside expected %0d actual %0d",
                                 $time, want.outside, node_bus.outside);
                    end
                end
                results_seen++;
                // hold off long enough for the pipeline to back up into the input
                if (results_seen == 200 || results_seen == 700)
                begin
                    hold_left = 150;
                end
            end
            cycle_count++;
            if (hold_left > 0)
            begin
                hold_left--;
                node_bus.ready <= 1'b0;
            end
            else
            begin
                case ((cycle_count >> 7) % 4)
                    0: node_bus.ready <= 1'b1;
                    1: node_bus.ready <= ($urandom_range(0, 1) == 1);
                    2: node_bus.ready <= (cycle_count % 3 == 0);
                    default: node_bus.ready <= ($urandom_range(0, 6) != 0);
                endcase
            end
        end
    end

    initial
    begin
        int          phase;
        int          a;
        logic [31:0] rnd;
        logic [3:0]  level_plan [8];
        level_plan = '{4'd8, 4'd1, 4'd4, 4'd0, 4'd15, 4'd6, 4'd8, 4'd2};
        mismatches = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ORIGIN_X;
        cfg_data = '0;
        box_bus.valid = 1'b0;
        box_bus.lo_x = '0;
        box_bus.lo_y = '0;
        box_bus.lo_z = '0;
        box_bus.hi_x = '0;
        box_bus.hi_y = '0;
        box_bus.hi_z = '0;
        node_bus.ready = 1'b0;
        vol_origin = '{32'd0, 32'd0, 32'd0};
        vol_inv_cell = '{32'd65536, 32'd65536, 32'd65536};
        vol_levels = 4'd1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Unit cells, eight levels: cell is the integer part of each coordinate
        write_reg(REG_ORIGIN_X, 32'd0);
        write_reg(REG_ORIGIN_Y, 32'd0);
        write_reg(REG_ORIGIN_Z, 32'd0);
        write_reg(REG_INV_CELL_X, 32'd65536);
        write_reg(REG_INV_CELL_Y, 32'd65536);
        write_reg(REG_INV_CELL_Z, 32'd65536);
        write_reg(REG_TREE_LEVELS, 32'd8);
        @(negedge clk);
        queue_box(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_box(32'd0, 32'd0, 32'd0, 255 << 16, 255 << 16, 255 << 16);
        queue_box(1 << 16, 2 << 16, 3 << 16, (1 << 16) + 32'h8000, (2 << 16) + 32'he000,
                  (3 << 16) + 32'h1000);
        queue_box(2 << 16, 2 << 16, 2 << 16, 3 << 16, 3 << 16, 3 << 16);
        queue_box(-1 << 16, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_box(32'd0, 32'd0, 32'd0, 256 << 16, 32'd0, 32'd0);
        queue_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_box(200 << 16, 100 << 16, 50 << 16, 10 << 16, 20 << 16, 30 << 16);
        queue_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_box(32'hffff_ffff, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_box(128 << 16, 32'd0, 32'd0, 127 << 16, 32'd0, 32'd0);
        queue_box(64 << 16, 64 << 16, 64 << 16, 127 << 16, 127 << 16, 127 << 16);
        wait_idle();

        // Level zero behaves as a single level
        write_reg(REG_TREE_LEVELS, 32'd0);
        @(negedge clk);
        queue_box(32'd0, 32'd0, 32'd0, 1 << 16, 1 << 16, 1 << 16);
        queue_box(1 << 16, 32'd0, 32'd0, 1 << 16, 32'd0, 32'd0);
        queue_box(32'd0, 32'd0, 32'd0, 5 << 16, 32'd0, 32'd0);
        wait_idle();

        // Level count above the maximum behaves as the maximum
        write_reg(REG_TREE_LEVELS, 32'd15);
        @(negedge clk);
        queue_box(3 << 16, 5 << 16, 7 << 16, 3 << 16, 5 << 16, 7 << 16);
        queue_box(32'd0, 32'd0, 32'd0, 255 << 16, 255 << 16, 255 << 16);
        wait_idle();

        // Lowest origin with the largest reciprocal: widest offset, full product
        for (a = 0; a < NAXIS; a++)
        begin
            write_reg(cfg_reg_t'(REG_ORIGIN_X + a), 32'h8000_0000);
            write_reg(cfg_reg_t'(REG_INV_CELL_X + a), 32'hffff_ffff);
        end
        @(negedge clk);
        queue_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0001, 32'h8000_0000, 32'h8000_0001);
        wait_idle();

        // Zero reciprocal folds every offset at or above the origin into cell 0
        for (a = 0; a < NAXIS; a++)
        begin
            write_reg(cfg_reg_t'(REG_ORIGIN_X + a), 32'd0);
            write_reg(cfg_reg_t'(REG_INV_CELL_X + a), 32'd0);
        end
        @(negedge clk);
        queue_box(100 << 16, -3 << 16, 32'h7fff_ffff, 32'd0, 32'd0, 32'd0);
        queue_box(5 << 16, 5 << 16, 5 << 16, 9 << 16, 9 << 16, 9 << 16);
        wait_idle();

        // Random volume setups, each followed by a batch of boxes
        for (phase = 0; phase < 8; phase++)
        begin
            for (a = 0; a < NAXIS; a++)
            begin
                case ($urandom_range(0, 3))
                    0: rnd = 32'd0;
                    1: rnd = $urandom;
                    2: rnd = 32'($urandom_range(0, 1 << 21)) - (32'd1 << 20);
                    default: rnd = ($urandom_range(0, 1) == 1) ? 32'h7fff_ffff : 32'h8000_0000;
                endcase
                write_reg(cfg_reg_t'(REG_ORIGIN_X + a), rnd);
                case ($urandom_range(0, 6))
                    0: rnd = 32'd65536;
                    1: rnd = $urandom;
                    2: rnd = 32'hffff_ffff;
                    3: rnd = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'd65536;
                    4: rnd = 32'd1 << $urandom_range(10, 24);
                    default: rnd = $urandom_range(1, 65535);
                endcase
                write_reg(cfg_reg_t'(REG_INV_CELL_X + a), rnd);
            end
            // odd phases carry junk above the level field
            rnd = (phase % 2 == 1) ? $urandom : 32'd0;
            write_reg(REG_TREE_LEVELS, {rnd[31:4], level_plan[phase]});
            @(negedge clk);
            repeat (150) queue_random_box();
            wait_idle();
        end

        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/aoi_pkg.sv
src/aoi_if.sv
src/aoi_scale.sv
src/aoi_encode.sv
src/aoi_index.sv
src/aabb_to_linear_octree_index.sv
tb/tb.sv
